### sv/tssc_pkg.sv
`default_nettype none

package tssc_pkg;

   // Field widths
   localparam int TOKEN_W = 18;
   localparam int CNT_W   = 16;
   localparam int WIN_W   = 7;
   localparam int SCNT_W  = 3;
   localparam int RSN_W   = 3;

   // History ring and stop token slots
   localparam int HIST_DEPTH = 64;
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int STOP_SLOTS = 4;
   localparam int REG_SLOTS  = 4;
   localparam int USED_SLOTS = (STOP_SLOTS < REG_SLOTS) ? STOP_SLOTS : REG_SLOTS;

   // Stream and register port widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 18;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_NEW = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCOUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_A  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_B  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_C  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_D  = 3'd6;

   localparam logic [CNT_W-1:0] MAX_NEW_RESET = 16'd256;

   // Stop reasons
   localparam logic [RSN_W-1:0] RSN_NONE     = 3'd0;
   localparam logic [RSN_W-1:0] RSN_STOP_TOK = 3'd1;
   localparam logic [RSN_W-1:0] RSN_REPEAT   = 3'd2;
   localparam logic [RSN_W-1:0] RSN_MAX      = 3'd3;
   localparam logic [RSN_W-1:0] RSN_FINISHED = 3'd4;

   // Command from the controller to the repetition scanner
   typedef struct packed {
      logic               start;
      logic [WIN_W-1:0]   window;
      logic [CNT_W-1:0]   count;
      logic [HIST_AW-1:0] last_slot;
      logic               wr_en;
      logic [HIST_AW-1:0] wr_slot;
      logic [TOKEN_W-1:0] wr_token;
   } scan_cmd_type;

   // Scanner status back to the controller
   typedef struct packed {
      logic done;
      logic match;
   } scan_sts_type;

endpackage

`default_nettype wire

### sv/token_stream_stop_controller_top.sv
`default_nettype none

// Channel  Handshake               Payload
// req      req_tvalid/req_tready   tdata: token_id; tuser: sequence_start
// rsp      rsp_tvalid/rsp_tready   tdata: emitted_token, step_index;
//                                  tuser: emitted, notify, finished, stop_reason
// csr      csr_valid/csr_ready     csr_index, csr_data (always ready)
//
// A token that is not emitted goes from idle straight to the output stage. An
// emitted token adds the repetition scan: a start step, a bound check per
// period, and a read and a compare per tail position on the single history
// comparator (two-port ring, registered read). Reset is synchronous; the
// history needs no clearing pass. The next token is taken while a result waits
// in the output register; its own result then holds until that register empties.

module token_stream_stop_controller_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [tssc_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [17:0] token_id
   input  wire logic                                 req_tuser,  // [0] sequence_start
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [tssc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // [17:0] emitted_token,
                                                                 // [33:18] step_index
   output logic      [tssc_pkg::RSP_TUSER_W-1:0]     rsp_tuser,  // [0] emitted, [1] notify,
                                                                 // [2] finished,
                                                                 // [5:3] stop_reason
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tssc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tssc_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   // Configuration registers
   logic [tssc_pkg::CNT_W-1:0]   max_ff;
   logic [tssc_pkg::WIN_W-1:0]   win_ff;
   logic [tssc_pkg::SCNT_W-1:0]  scnt_ff;
   logic [tssc_pkg::TOKEN_W-1:0] stop_ff [tssc_pkg::REG_SLOTS];

   // Run state
   logic [1:0]                   state_ff, state_in;
   logic [tssc_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                         done_ff, done_in;
   logic [tssc_pkg::HIST_AW-1:0] slot_ff, slot_in;

   // Item in progress
   logic [tssc_pkg::TOKEN_W-1:0] tok_ff, tok_in;
   logic [tssc_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic                         emit_ff, emit_in;
   logic [tssc_pkg::RSN_W-1:0]   rsn_ff, rsn_in;

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tssc_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [tssc_pkg::RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                         accept;
   logic [tssc_pkg::TOKEN_W-1:0] tok;
   logic [tssc_pkg::CNT_W-1:0]   cnt_eff;
   logic                         done_eff;
   logic [tssc_pkg::HIST_AW-1:0] slot_eff;
   logic [tssc_pkg::HIST_AW-1:0] slot_next;
   logic [tssc_pkg::SCNT_W-1:0]  used;
   logic                         stop_hit;
   logic                         out_free;
   logic                         notify;

   tssc_pkg::scan_cmd_type       cmd;
   tssc_pkg::scan_sts_type       sts;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign tok        = req_tdata[tssc_pkg::TOKEN_W-1:0];
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Sequence start clears the run before this token
   assign cnt_eff  = req_tuser ? '0 : count_ff;
   assign done_eff = req_tuser ? 1'b0 : done_ff;
   assign slot_eff = req_tuser ? '0 : slot_ff;
   assign slot_next = (slot_eff == tssc_pkg::HIST_AW'(tssc_pkg::HIST_DEPTH - 1)) ?
                      '0 : slot_eff + 1'b1;

   // Stop token match over the slots in use
   assign used = (scnt_ff > tssc_pkg::SCNT_W'(tssc_pkg::USED_SLOTS)) ?
                 tssc_pkg::SCNT_W'(tssc_pkg::USED_SLOTS) : scnt_ff;

   always_comb begin
      stop_hit = 1'b0;
      for (int k = 0; k < tssc_pkg::USED_SLOTS; k++) begin
         if ((tssc_pkg::SCNT_W'(k) < used) && (stop_ff[k] == tok)) begin
            stop_hit = 1'b1;
         end
      end
   end

   // Repetition scanner and history ring
   tssc_scan u_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   // Controller
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      done_in       = done_ff;
      slot_in       = slot_ff;
      tok_in        = tok_ff;
      idx_in        = idx_ff;
      emit_in       = emit_ff;
      rsn_in        = rsn_ff;
      cmd.start     = 1'b0;
      cmd.window    = win_ff;
      cmd.count     = cnt_eff + 1'b1;
      cmd.last_slot = slot_eff;
      cmd.wr_en     = 1'b0;
      cmd.wr_slot   = slot_eff;
      cmd.wr_token  = tok;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tok_in   = tok;
               idx_in   = cnt_eff;
               count_in = cnt_eff;
               done_in  = done_eff;
               slot_in  = slot_eff;
               emit_in  = 1'b0;
               state_in = ST_FIN;
               if (done_eff) begin
                  rsn_in = tssc_pkg::RSN_FINISHED;
               end else if (cnt_eff >= max_ff) begin
                  rsn_in  = tssc_pkg::RSN_MAX;
                  done_in = 1'b1;
               end else if (stop_hit) begin
                  rsn_in  = tssc_pkg::RSN_STOP_TOK;
                  done_in = 1'b1;
               end else begin
                  // emit: append to history and scan the tail
                  emit_in   = 1'b1;
                  count_in  = cnt_eff + 1'b1;
                  slot_in   = slot_next;
                  cmd.wr_en = 1'b1;
                  cmd.start = 1'b1;
                  rsn_in    = tssc_pkg::RSN_NONE;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sts.done) begin
               state_in = ST_FIN;
               if (sts.match) begin
                  rsn_in  = tssc_pkg::RSN_REPEAT;
                  done_in = 1'b1;
               end else if (count_ff >= max_ff) begin
                  rsn_in  = tssc_pkg::RSN_MAX;
                  done_in = 1'b1;
               end else begin
                  rsn_in = tssc_pkg::RSN_NONE;
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register load
   assign notify = emit_ff && (rsn_ff == tssc_pkg::RSN_NONE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if ((state_ff == ST_FIN) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, idx_ff, tok_ff};
         rsp_user_in  = {rsn_ff, done_ff, notify, emit_ff};
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= tssc_pkg::MAX_NEW_RESET;
         win_ff  <= '0;
         scnt_ff <= '0;
         for (int k = 0; k < tssc_pkg::REG_SLOTS; k++) begin
            stop_ff[k] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tssc_pkg::REG_MAX_NEW: max_ff     <= csr_data[tssc_pkg::CNT_W-1:0];
            tssc_pkg::REG_WINDOW:  win_ff     <= csr_data[tssc_pkg::WIN_W-1:0];
            tssc_pkg::REG_SCOUNT:  scnt_ff    <= csr_data[tssc_pkg::SCNT_W-1:0];
            tssc_pkg::REG_STOP_A:  stop_ff[0] <= csr_data[tssc_pkg::TOKEN_W-1:0];
            tssc_pkg::REG_STOP_B:  stop_ff[1] <= csr_data[tssc_pkg::TOKEN_W-1:0];
            tssc_pkg::REG_STOP_C:  stop_ff[2] <= csr_data[tssc_pkg::TOKEN_W-1:0];
            tssc_pkg::REG_STOP_D:  stop_ff[3] <= csr_data[tssc_pkg::TOKEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      tok_ff      <= tok_in;
      idx_ff      <= idx_in;
      emit_ff     <= emit_in;
      rsn_ff      <= rsn_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### sv/tssc_ram.sv
`default_nettype none

module tssc_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr_a,
   output logic      [WIDTH-1:0] rd_data_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // One write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

### sv/tssc_scan.sv
`default_nettype none

module tssc_scan (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tssc_pkg::scan_cmd_type  cmd,
   output tssc_pkg::scan_sts_type       sts
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_PERIOD = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;
   localparam logic [1:0] S_CMP    = 2'd3;

   localparam int SUM_W = tssc_pkg::CNT_W + 1;

   logic [1:0]                   state_ff, state_in;
   logic [tssc_pkg::WIN_W-1:0]   per_ff, per_in;
   logic [tssc_pkg::WIN_W-1:0]   step_ff, step_in;
   logic [tssc_pkg::WIN_W-1:0]   win_ff, win_in;
   logic [tssc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [tssc_pkg::HIST_AW-1:0] last_ff, last_in;
   logic [tssc_pkg::HIST_AW-1:0] a_ff, a_in;
   logic [tssc_pkg::HIST_AW-1:0] b_ff, b_in;
   logic                         done_ff, done_in;
   logic                         match_ff, match_in;

   logic [tssc_pkg::TOKEN_W-1:0] qa, qb;
   logic [tssc_pkg::WIN_W-1:0]   half;
   logic [SUM_W-1:0]             span;
   logic [SUM_W-1:0]             b_first;
   logic                         per_ok;
   logic [tssc_pkg::HIST_AW-1:0] a_dec, b_dec;

   // History ring: written by the controller, read at two tail offsets
   tssc_ram #(
      .WIDTH (tssc_pkg::TOKEN_W),
      .DEPTH (tssc_pkg::HIST_DEPTH)
   ) u_hist (
      .clock     (clock),
      .wr_en     (cmd.wr_en),
      .wr_addr   (cmd.wr_slot),
      .wr_data   (cmd.wr_token),
      .rd_addr_a (a_ff),
      .rd_data_a (qa),
      .rd_addr_b (b_ff),
      .rd_data_b (qb)
   );

   // Period bounds: p <= w/2, w+p inside the ring, w+p tokens emitted
   assign half   = win_ff >> 1;
   assign span   = SUM_W'(win_ff) + SUM_W'(per_ff);
   assign per_ok = (per_ff <= half) && (span <= SUM_W'(tssc_pkg::HIST_DEPTH))
                   && (span <= {1'b0, cnt_ff});

   // Slot p positions behind the newest one, wrapped
   always_comb begin
      if (SUM_W'(per_ff) > SUM_W'(last_ff)) begin
         b_first = SUM_W'(last_ff) + SUM_W'(tssc_pkg::HIST_DEPTH) - SUM_W'(per_ff);
      end else begin
         b_first = SUM_W'(last_ff) - SUM_W'(per_ff);
      end
   end

   assign a_dec = (a_ff == '0) ? tssc_pkg::HIST_AW'(tssc_pkg::HIST_DEPTH - 1) : a_ff - 1'b1;
   assign b_dec = (b_ff == '0) ? tssc_pkg::HIST_AW'(tssc_pkg::HIST_DEPTH - 1) : b_ff - 1'b1;

   // Scan sequencer: one shared compare, a read state and a compare state per tail position
   always_comb begin
      state_in = state_ff;
      per_in   = per_ff;
      step_in  = step_ff;
      win_in   = win_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      done_in  = 1'b0;
      match_in = match_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               win_in   = cmd.window;
               cnt_in   = cmd.count;
               last_in  = cmd.last_slot;
               per_in   = tssc_pkg::WIN_W'(1);
               state_in = S_PERIOD;
            end
         end
         S_PERIOD: begin
            if (per_ok) begin
               a_in     = last_ff;
               b_in     = tssc_pkg::HIST_AW'(b_first);
               step_in  = '0;
               state_in = S_READ;
            end else begin
               // larger periods only fail harder
               done_in  = 1'b1;
               match_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (qa != qb) begin
               per_in   = per_ff + 1'b1;
               state_in = S_PERIOD;
            end else if (step_ff == win_ff - 1'b1) begin
               done_in  = 1'b1;
               match_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               step_in  = step_ff + 1'b1;
               a_in     = a_dec;
               b_in     = b_dec;
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      per_ff   <= per_in;
      step_ff  <= step_in;
      win_ff   <= win_in;
      cnt_ff   <= cnt_in;
      last_ff  <= last_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      match_ff <= match_in;
   end

   assign sts.done  = done_ff;
   assign sts.match = match_ff;

endmodule

`default_nettype wire

### sv/tssc_checker.sv
`default_nettype none

module tssc_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_tvalid,
   input wire logic                                 req_tready,
   input wire logic [tssc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input wire logic                                 req_tuser,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [tssc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input wire logic [tssc_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   input wire logic                                 csr_valid,
   input wire logic                                 csr_ready,
   input wire logic [tssc_pkg::CSR_IDX_W-1:0]       csr_index,
   input wire logic [tssc_pkg::CSR_DATA_W-1:0]      csr_data
);

   // One token at a time: ready drops after every accepted beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready stayed high after an accepted beat");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Notify only for an emitted token with the run still going
   a_notify: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         rsp_tuser[0] && !rsp_tuser[2] && (rsp_tuser[5:3] == tssc_pkg::RSN_NONE))
      else $error("notify on a token that was not emitted or ended the run");

   // A dropped token always means the run has finished with a reason
   a_dropped_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_tuser[2] && (rsp_tuser[5:3] != tssc_pkg::RSN_NONE)
         && (rsp_tuser[5:3] != tssc_pkg::RSN_REPEAT))
      else $error("dropped token without a finished run");

endmodule

bind token_stream_stop_controller_top tssc_checker u_tssc_checker (.*);

`default_nettype wire
